[src/peg_pkg.sv]
// shared types, constants and helpers for the punch envelope generator
// no dependencies
package peg_pkg;

	localparam int WF = 16;                       // weight fraction bits
	localparam logic [16:0] W_ONE = 17'h10000;
	localparam logic [25:0] ELAPSED_MAX = 26'h3FFFFFF;

	// operand widths of the shared serial units
	localparam int MUL_AW = 34;
	localparam int MUL_BW = 24;
	localparam int MUL_PW = MUL_AW + MUL_BW;
	localparam int DIV_NW = 40;
	localparam int DIV_DW = 24;

	typedef enum logic [1:0] {
		OP_TICK    = 2'd0,
		OP_TRIGGER = 2'd1,
		OP_DEACT   = 2'd2,
		OP_ACT     = 2'd3
	} op_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_TICK_CMP,
		ST_A_DIV,
		ST_A_SQ,
		ST_A_CUBE,
		ST_R_DIV,
		ST_R_SQ,
		ST_R_POLY,
		ST_BLUR,
		ST_T_CUR,
		ST_T_DIV,
		ST_CB_INIT,
		ST_CB_SQ,
		ST_CB_CUBE,
		ST_T_EL,
		ST_SC_FOV,
		ST_SC_DOL,
		ST_DONE
	} state_t;

	// magnitude of a signed Q8.8 value
	function automatic logic [15:0] mag16(input logic signed [15:0] v);
		mag16 = v[15] ? 16'(-v) : 16'(v);
	endfunction

	// round magnitude product to nearest, ties away, then apply sign
	function automatic logic [15:0] round_signed(input logic neg, input logic [33:0] p);
		logic [33:0] s;
		logic [15:0] r;
		s = p + 34'd32768;
		r = s[31:16];
		round_signed = neg ? 16'(-r) : r;
	endfunction

endpackage

[src/peg_mul.sv]
// shift-and-add multiplier, one multiplier bit per cycle
// depends on peg_pkg
module peg_mul import peg_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [MUL_AW-1:0]   a,
	input  logic [MUL_BW-1:0]   b,
	output logic                done,
	output logic [MUL_PW-1:0]   p
);
	logic [MUL_PW-1:0] acc_q;
	logic [MUL_PW-1:0] a_q;
	logic [MUL_BW-1:0] b_q;
	logic [4:0]        cnt_q;
	logic              busy_q;
	logic              done_q;

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'(MUL_BW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			a_q   <= {{MUL_BW{1'b0}}, a};
			b_q   <= b;
		end else if (busy_q) begin
			if (b_q[0]) acc_q <= acc_q + a_q;
			a_q <= {a_q[MUL_PW-2:0], 1'b0};
			b_q <= {1'b0, b_q[MUL_BW-1:1]};
		end
	end

	assign done = done_q;
	assign p    = acc_q;
endmodule

[src/peg_div.sv]
// restoring divider, one quotient bit per cycle
// depends on peg_pkg
module peg_div import peg_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [DIV_NW-1:0]  dividend,
	input  logic [DIV_DW-1:0]  divisor,
	output logic               done,
	output logic [DIV_NW-1:0]  quotient
);
	logic [DIV_NW-1:0] q_q;
	logic [DIV_DW-1:0] rem_q;
	logic [DIV_DW-1:0] dvs_q;
	logic [5:0]        cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [DIV_DW:0]   shifted;
	logic [DIV_DW:0]   trial;

	assign shifted = {rem_q, q_q[DIV_NW-1]};
	assign trial   = shifted - {1'b0, dvs_q};

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'(DIV_NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			q_q   <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (!trial[DIV_DW]) begin
				rem_q <= trial[DIV_DW-1:0];
				q_q   <= {q_q[DIV_NW-2:0], 1'b1};
			end else begin
				rem_q <= shifted[DIV_DW-1:0];
				q_q   <= {q_q[DIV_NW-2:0], 1'b0};
			end
		end
	end

	assign done     = done_q;
	assign quotient = q_q;
endmodule

[src/punch_envelope_generator.sv]
// top level: request sequencer, envelope state and output register
// depends on peg_pkg, peg_mul, peg_div
//
// Retriggerable attack-hold-release envelope. One request is worked on at a
// time and every request gives exactly one result. Arithmetic runs on one
// shared shift-add multiplier and one restoring divider. A multiplier pass
// steps through the 24 multiplier bits between launch and done, and a
// divider pass through the 40 quotient bits, so the time a request takes is
// set by the number of passes. A full trigger takes longest: the 17-step
// cube root, whose steps each square and cube a trial root on the
// multiplier, is the long pole, and the divider pass is skipped when the new
// peak FOV is zero and no envelope is running.
// The result sits in an output register. The next request is taken once the
// previous result has been loaded there, in the following cycle at the
// earliest. A full output register holds the sequencer until its result is
// taken.
module punch_envelope_generator import peg_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         op,
	input  logic [23:0]        scaled_delta,
	input  logic [23:0]        raw_delta,
	input  logic signed [15:0] peak_fov,
	input  logic signed [15:0] peak_dolly,
	input  logic signed [15:0] peak_blur,
	input  logic [23:0]        attack_time,
	input  logic [23:0]        hold_time,
	input  logic [23:0]        release_time,
	input  logic               ignore_scale,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [16:0]        weight,
	output logic signed [15:0] fov_offset,
	output logic signed [15:0] dolly_offset,
	output logic signed [15:0] blur_amount,
	output logic               blur_write,
	output logic               envelope_running
);
	state_t state_q, state_d;

	// envelope state
	logic        enabled_q, running_q, use_raw_q, blur_pushed_q;
	logic [25:0] elapsed_q;
	logic [23:0] attack_q, hold_q, release_q;
	logic [15:0] fov_pk_q, dolly_pk_q, blur_pk_q;
	logic [16:0] level_q;

	// latched request
	op_t         op_q;
	logic [23:0] delta_q, att_in_q, hold_in_q, rel_in_q;
	logic [15:0] nf_q, nd_q, nb_q;
	logic        raw_in_q;

	// working registers
	logic [33:0] tmp_q;
	logic [16:0] u_q, sw_q, c_q, x_q;
	logic [4:0]  bit_q;
	logic        launched_q;
	logic        wrote_q;
	logic [15:0] blur_v_q, fov_v_q, dolly_v_q;

	// output register
	logic        out_valid_q, out_wr_q, out_run_q;
	logic [16:0] out_w_q;
	logic [15:0] out_fov_q, out_dol_q, out_blur_q;

	// shared units
	logic              mul_start, mul_done, div_start, div_done;
	logic [MUL_AW-1:0] mul_a;
	logic [MUL_BW-1:0] mul_b;
	logic [MUL_PW-1:0] mul_p;
	logic [DIV_NW-1:0] div_n, div_q;
	logic [DIV_DW-1:0] div_d;
	logic              use_mul, use_div;

	// tick-time arithmetic
	logic [25:0] total, t1, t2;
	logic [26:0] el_sum;
	logic [16:0] cb_t, cb_c, cube_inv;
	logic [41:0] prod_hi;
	logic [18:0] poly_b;
	logic [15:0] nmag, blur_r;
	logic [33:0] cur;

	assign total    = 26'(attack_q) + 26'(hold_q) + 26'(release_q);
	assign t1       = elapsed_q - 26'(attack_q);
	assign t2       = t1 - 26'(hold_q);
	assign el_sum   = 27'(elapsed_q) + 27'(delta_q);
	assign cb_t     = c_q | (17'd1 << bit_q);
	assign cb_c     = (c_q > W_ONE) ? W_ONE : c_q;
	assign prod_hi  = mul_p[57:16];
	assign cube_inv = prod_hi[16:0];
	assign poly_b   = 19'(3 * W_ONE) - {1'b0, u_q, 1'b0};
	assign nmag     = mag16(nf_q);
	assign cur      = mul_p[33:0];
	assign blur_r   = round_signed(blur_pk_q[15], mul_p[33:0]);

	peg_mul u_mul (
		.clk(clk), .arst_n(arst_n), .start(mul_start),
		.a(mul_a), .b(mul_b), .done(mul_done), .p(mul_p)
	);

	peg_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.dividend(div_n), .divisor(div_d), .done(div_done), .quotient(div_q)
	);

	// unit operand selection
	always_comb begin
		use_mul = 1'b0;
		use_div = 1'b0;
		mul_a   = '0;
		mul_b   = '0;
		div_n   = '0;
		div_d   = '0;
		case (state_q)
			ST_A_DIV: begin
				use_div = 1'b1;
				div_n   = {elapsed_q[23:0], 16'd0};
				div_d   = attack_q;
			end
			ST_R_DIV: begin
				use_div = 1'b1;
				div_n   = {t2[23:0], 16'd0};
				div_d   = release_q;
			end
			ST_T_DIV: begin
				use_div = 1'b1;
				div_n   = {6'd0, tmp_q};
				div_d   = {8'd0, nmag};
			end
			ST_A_SQ, ST_R_SQ: begin
				use_mul = 1'b1;
				mul_a   = {17'd0, u_q};
				mul_b   = {7'd0, u_q};
			end
			ST_A_CUBE: begin
				use_mul = 1'b1;
				mul_a   = tmp_q;
				mul_b   = {7'd0, u_q};
			end
			ST_R_POLY: begin
				use_mul = 1'b1;
				mul_a   = tmp_q;
				mul_b   = {5'd0, poly_b};
			end
			ST_BLUR: begin
				use_mul = 1'b1;
				mul_a   = {18'd0, mag16(blur_pk_q)};
				mul_b   = {7'd0, level_q};
			end
			ST_T_CUR, ST_SC_FOV: begin
				use_mul = 1'b1;
				mul_a   = {18'd0, mag16(fov_pk_q)};
				mul_b   = {7'd0, level_q};
			end
			ST_SC_DOL: begin
				use_mul = 1'b1;
				mul_a   = {18'd0, mag16(dolly_pk_q)};
				mul_b   = {7'd0, level_q};
			end
			ST_CB_SQ: begin
				use_mul = 1'b1;
				mul_a   = {17'd0, cb_t};
				mul_b   = {7'd0, cb_t};
			end
			ST_CB_CUBE: begin
				use_mul = 1'b1;
				mul_a   = tmp_q;
				mul_b   = {7'd0, cb_t};
			end
			ST_T_EL: begin
				use_mul = 1'b1;
				mul_a   = {17'd0, u_q};
				mul_b   = att_in_q;
			end
			default: ;
		endcase
	end

	assign mul_start = use_mul && !launched_q;
	assign div_start = use_div && !launched_q;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_d;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:     if (in_valid) state_d = ST_DISPATCH;
			ST_DISPATCH: begin
				case (op_q)
					OP_TICK:    state_d = running_q ? ST_TICK_CMP : ST_SC_FOV;
					OP_TRIGGER: state_d = enabled_q ? ST_T_CUR : ST_SC_FOV;
					default:    state_d = ST_SC_FOV;
				endcase
			end
			ST_TICK_CMP: begin
				if (elapsed_q >= total)                 state_d = ST_SC_FOV;
				else if (elapsed_q < 26'(attack_q))     state_d = ST_A_DIV;
				else if (t1 < 26'(hold_q))              state_d = ST_BLUR;
				else                                    state_d = ST_R_DIV;
			end
			ST_A_DIV:  if (div_done) state_d = ST_A_SQ;
			ST_A_SQ:   if (mul_done) state_d = ST_A_CUBE;
			ST_A_CUBE: if (mul_done) state_d = ST_BLUR;
			ST_R_DIV:  if (div_done) state_d = ST_R_SQ;
			ST_R_SQ:   if (mul_done) state_d = ST_R_POLY;
			ST_R_POLY: if (mul_done) state_d = ST_BLUR;
			ST_BLUR:   if (mul_done) state_d = ST_SC_FOV;
			ST_T_CUR: begin
				if (mul_done) begin
					if (running_q && cur >= {2'd0, nmag, 16'd0}) state_d = ST_SC_FOV;
					else if (nmag == 16'd0)                      state_d = ST_CB_INIT;
					else                                         state_d = ST_T_DIV;
				end
			end
			ST_T_DIV:   if (div_done) state_d = ST_CB_INIT;
			ST_CB_INIT: state_d = ST_CB_SQ;
			ST_CB_SQ:   if (mul_done) state_d = ST_CB_CUBE;
			ST_CB_CUBE: if (mul_done) state_d = (bit_q == 5'd0) ? ST_T_EL : ST_CB_SQ;
			ST_T_EL:    if (mul_done) state_d = ST_SC_FOV;
			ST_SC_FOV:  if (mul_done) state_d = ST_SC_DOL;
			ST_SC_DOL:  if (mul_done) state_d = ST_DONE;
			ST_DONE:    if (!out_valid_q || out_ready) state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	assign in_ready = (state_q == ST_IDLE);

	// unit launch tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) launched_q <= 1'b0;
		else if (mul_done || div_done) launched_q <= 1'b0;
		else if (mul_start || div_start) launched_q <= 1'b1;
	end

	// envelope control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q     <= 1'b1;
			running_q     <= 1'b0;
			use_raw_q     <= 1'b0;
			blur_pushed_q <= 1'b0;
			elapsed_q     <= '0;
			attack_q      <= '0;
			hold_q        <= '0;
			release_q     <= '0;
			fov_pk_q      <= '0;
			dolly_pk_q    <= '0;
			blur_pk_q     <= '0;
			level_q       <= '0;
			wrote_q       <= 1'b0;
			blur_v_q      <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					wrote_q  <= 1'b0;
					blur_v_q <= '0;
				end
				ST_DISPATCH: begin
					case (op_q)
						OP_TICK: begin
							if (running_q)
								elapsed_q <= el_sum[26] ? ELAPSED_MAX : el_sum[25:0];
						end
						OP_DEACT: begin
							if (enabled_q) begin
								fov_pk_q   <= '0;
								dolly_pk_q <= '0;
								blur_pk_q  <= '0;
								running_q  <= 1'b0;
								elapsed_q  <= '0;
								level_q    <= '0;
								if (blur_pushed_q) begin
									wrote_q       <= 1'b1;
									blur_pushed_q <= 1'b0;
								end
							end
							enabled_q <= 1'b0;
						end
						OP_ACT: enabled_q <= 1'b1;
						default: ;
					endcase
				end
				ST_TICK_CMP: begin
					if (elapsed_q >= total) begin
						running_q <= 1'b0;
						level_q   <= '0;
						if (blur_pushed_q) begin
							wrote_q       <= 1'b1;
							blur_pushed_q <= 1'b0;
						end
					end else if (elapsed_q >= 26'(attack_q) && t1 < 26'(hold_q)) begin
						level_q <= W_ONE;
					end
				end
				ST_A_CUBE: if (mul_done) level_q <= W_ONE - cube_inv;
				ST_R_POLY: begin
					if (mul_done)
						level_q <= (prod_hi > 42'(W_ONE)) ? 17'd0 : W_ONE - prod_hi[16:0];
				end
				ST_BLUR: begin
					if (mul_done) begin
						if ((!blur_r[15] && blur_r != 16'd0) || blur_pushed_q) begin
							wrote_q       <= 1'b1;
							blur_v_q      <= blur_r;
							blur_pushed_q <= !blur_r[15] && blur_r != 16'd0;
						end
					end
				end
				ST_T_EL: begin
					if (mul_done) begin
						fov_pk_q   <= nf_q;
						dolly_pk_q <= nd_q;
						blur_pk_q  <= nb_q;
						attack_q   <= att_in_q;
						hold_q     <= hold_in_q;
						release_q  <= rel_in_q;
						use_raw_q  <= raw_in_q;
						elapsed_q  <= prod_hi[25:0];
						level_q    <= sw_q;
						running_q  <= 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// request latch and working datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					op_q      <= op_t'(op);
					delta_q   <= use_raw_q ? raw_delta : scaled_delta;
					nf_q      <= peak_fov;
					nd_q      <= peak_dolly;
					nb_q      <= peak_blur;
					att_in_q  <= attack_time;
					hold_in_q <= hold_time;
					rel_in_q  <= release_time;
					raw_in_q  <= ignore_scale;
				end
			end
			ST_A_DIV:  if (div_done) u_q <= W_ONE - {1'b0, div_q[15:0]};
			ST_R_DIV:  if (div_done) u_q <= {1'b0, div_q[15:0]};
			ST_A_SQ, ST_R_SQ, ST_CB_SQ: if (mul_done) tmp_q <= mul_p[49:16];
			ST_T_CUR: begin
				if (mul_done) begin
					tmp_q <= cur;
					sw_q  <= '0;
				end
			end
			ST_T_DIV: begin
				if (div_done)
					sw_q <= (div_q > 40'(W_ONE)) ? W_ONE : div_q[16:0];
			end
			ST_CB_INIT: begin
				x_q   <= W_ONE - sw_q;
				c_q   <= '0;
				bit_q <= 5'(WF);
			end
			ST_CB_CUBE: begin
				if (mul_done) begin
					if (prod_hi <= 42'(x_q)) begin
						c_q <= cb_t;
						if (bit_q == 5'd0) u_q <= W_ONE - ((cb_t > W_ONE) ? W_ONE : cb_t);
					end else if (bit_q == 5'd0) begin
						u_q <= W_ONE - cb_c;
					end
					bit_q <= bit_q - 5'd1;
				end
			end
			ST_SC_FOV: if (mul_done) fov_v_q <= round_signed(fov_pk_q[15], mul_p[33:0]);
			ST_SC_DOL: if (mul_done) dolly_v_q <= round_signed(dolly_pk_q[15], mul_p[33:0]);
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && (!out_valid_q || out_ready)) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && (!out_valid_q || out_ready)) begin
			out_w_q    <= level_q;
			out_fov_q  <= fov_v_q;
			out_dol_q  <= dolly_v_q;
			out_blur_q <= blur_v_q;
			out_wr_q   <= wrote_q;
			out_run_q  <= running_q;
		end
	end

	assign out_valid        = out_valid_q;
	assign weight           = out_w_q;
	assign fov_offset       = out_fov_q;
	assign dolly_offset     = out_dol_q;
	assign blur_amount      = out_blur_q;
	assign blur_write       = out_wr_q;
	assign envelope_running = out_run_q;

	// checks
	a_run_en: assert property (@(posedge clk) disable iff (!arst_n)
		running_q |-> enabled_q) else $error("running while disabled");
	a_idle_lvl: assert property (@(posedge clk) disable iff (!arst_n)
		!running_q |-> level_q == 17'd0) else $error("level nonzero while idle");
	a_lvl_max: assert property (@(posedge clk) disable iff (!arst_n)
		level_q <= W_ONE) else $error("level above one");
	a_done_launch: assert property (@(posedge clk) disable iff (!arst_n)
		(mul_done || div_done) |-> launched_q) else $error("unit done without launch");
endmodule
